// ----- rtl/tmr_pkg.sv -----
// Shared types, constants and control structs for the one-shot and periodic timer table.
`default_nettype none

package tmr_pkg;

    localparam int ONESHOT_SLOTS = 16;
    localparam int TICKER_SLOTS  = 16;

    localparam int OS_IW = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
    localparam int TK_IW = (TICKER_SLOTS > 1) ? $clog2(TICKER_SLOTS) : 1;
    localparam int IDX_W = (OS_IW > TK_IW) ? OS_IW : TK_IW;

    localparam int REQ_W  = 2;
    localparam int CB_W   = 16;
    localparam int KEY_W  = 16;
    localparam int IVL_W  = 32;
    localparam int TIME_W = 63;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;

    localparam logic [REQ_W-1:0] REQ_ADD_ONESHOT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_TICKER  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP_TICKER = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK        = 2'd3;

    localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONESHOT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICKER  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_CB    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_DUP_NAME  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CB_W-1:0]   callback_id;
        logic [KEY_W-1:0]  name_key;
        logic [IVL_W-1:0]  interval;
        logic [TIME_W-1:0] now;
    } tmr_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CB_W-1:0]   fired_callback;
        logic [STAT_W-1:0] status;
        logic              last;
    } tmr_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_req;
        logic              idx_clr;
        logic              idx_inc;
        logic              read;
        logic              diff;
        logic              phase_tk;
        logic              set_status;
        logic [STAT_W-1:0] status_val;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              os_write;
        logic              os_clear;
        logic              tk_mark_dup;
        logic              tk_mark_free;
        logic              tk_write;
        logic              tk_stop;
        logic              tk_reload;
        logic              tk_free;
    } tmr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             cb_zero;
        logic             phase_tk;
        logic             slot_valid;
        logic             slot_running;
        logic             key_match;
        logic             fire;
        logic             idx_last;
        logic             dup;
        logic             free_found;
        logic             out_free;
    } tmr_sts_t;

endpackage

`default_nettype wire

// ----- rtl/tmr_dp.sv -----
// Datapath of the timer table: slot storage, scan index, elapsed-time compare, result register.
`default_nettype none

module tmr_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  tmr_pkg::tmr_req_t req_data,
    input  tmr_pkg::tmr_cmd_t cmd,
    output tmr_pkg::tmr_sts_t sts,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tmr_pkg::tmr_rsp_t rsp_data
);
    import tmr_pkg::*;

    // Slot storage; read-back data of an entry is only used while its valid bit is set.
    logic [CB_W-1:0]   os_cb_mem    [ONESHOT_SLOTS];
    logic [TIME_W-1:0] os_start_mem [ONESHOT_SLOTS];
    logic [IVL_W-1:0]  os_wait_mem  [ONESHOT_SLOTS];
    logic [KEY_W-1:0]  tk_key_mem   [TICKER_SLOTS];
    logic [CB_W-1:0]   tk_cb_mem    [TICKER_SLOTS];
    logic [TIME_W-1:0] tk_start_mem [TICKER_SLOTS];
    logic [IVL_W-1:0]  tk_period_mem[TICKER_SLOTS];

    logic [CB_W-1:0]   os_cb_rd_reg;
    logic [TIME_W-1:0] os_start_rd_reg;
    logic [IVL_W-1:0]  os_wait_rd_reg;
    logic [KEY_W-1:0]  tk_key_rd_reg;
    logic [CB_W-1:0]   tk_cb_rd_reg;
    logic [TIME_W-1:0] tk_start_rd_reg;
    logic [IVL_W-1:0]  tk_period_rd_reg;

    tmr_req_t          req_reg;
    logic [TIME_W:0]   diff_reg;

    logic                     phase_reg, phase_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     dup_reg, dup_next;
    logic                     free_found_reg, free_found_next;
    logic [TK_IW-1:0]         free_reg, free_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic [ONESHOT_SLOTS-1:0] os_valid_reg, os_valid_next;
    logic [TICKER_SLOTS-1:0]  tk_valid_reg, tk_valid_next;
    logic [TICKER_SLOTS-1:0]  tk_running_reg, tk_running_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    tmr_rsp_t                 rsp_reg, rsp_next;

    logic [OS_IW-1:0]  os_idx;
    logic [TK_IW-1:0]  tk_idx;
    logic [TK_IW-1:0]  tk_waddr;
    logic [TIME_W:0]   gap;
    logic              os_due;
    logic              tk_due;

    assign os_idx   = idx_reg[OS_IW-1:0];
    assign tk_idx   = idx_reg[TK_IW-1:0];
    assign tk_waddr = cmd.tk_write ? free_reg : tk_idx;

    // Elapsed time is the magnitude of now minus the stored start.
    assign gap    = diff_reg[TIME_W] ? ((TIME_W+1)'(0) - diff_reg) : diff_reg;
    assign os_due = {{(TIME_W+1-IVL_W){1'b0}}, os_wait_rd_reg} <= gap;
    assign tk_due = {{(TIME_W+1-IVL_W){1'b0}}, tk_period_rd_reg} <= gap;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.diff)
        begin
            diff_reg <= {1'b0, req_reg.now}
                      - {1'b0, (phase_reg ? tk_start_rd_reg : os_start_rd_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.os_write)
        begin
            os_cb_mem[os_idx]    <= req_reg.callback_id;
            os_start_mem[os_idx] <= req_reg.now;
            os_wait_mem[os_idx]  <= req_reg.interval;
        end
        if (cmd.read)
        begin
            os_cb_rd_reg    <= os_cb_mem[os_idx];
            os_start_rd_reg <= os_start_mem[os_idx];
            os_wait_rd_reg  <= os_wait_mem[os_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tk_write)
        begin
            tk_key_mem[tk_waddr]    <= req_reg.name_key;
            tk_cb_mem[tk_waddr]     <= req_reg.callback_id;
            tk_period_mem[tk_waddr] <= req_reg.interval;
        end
        if (cmd.tk_write || cmd.tk_reload)
        begin
            tk_start_mem[tk_waddr] <= req_reg.now;
        end
        if (cmd.read)
        begin
            tk_key_rd_reg    <= tk_key_mem[tk_idx];
            tk_cb_rd_reg     <= tk_cb_mem[tk_idx];
            tk_start_rd_reg  <= tk_start_mem[tk_idx];
            tk_period_rd_reg <= tk_period_mem[tk_idx];
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        status_next     = status_reg;
        os_valid_next   = os_valid_reg;
        tk_valid_next   = tk_valid_reg;
        tk_running_next = tk_running_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        if (cmd.load_req)
        begin
            phase_next      = (req_data.req_type == REQ_ADD_TICKER) ||
                              (req_data.req_type == REQ_STOP_TICKER);
            dup_next        = 1'b0;
            free_found_next = 1'b0;
        end
        if (cmd.phase_tk)
        begin
            phase_next = 1'b1;
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.tk_mark_dup)
        begin
            dup_next = 1'b1;
        end
        if (cmd.tk_mark_free)
        begin
            free_found_next = 1'b1;
            free_next       = tk_idx;
        end
        if (cmd.set_status)
        begin
            status_next = cmd.status_val;
        end
        if (cmd.os_write)
        begin
            os_valid_next[os_idx] = 1'b1;
        end
        if (cmd.os_clear)
        begin
            os_valid_next[os_idx] = 1'b0;
        end
        if (cmd.tk_write)
        begin
            tk_valid_next[free_reg]   = 1'b1;
            tk_running_next[free_reg] = 1'b1;
        end
        if (cmd.tk_stop)
        begin
            tk_running_next[tk_idx] = 1'b0;
        end
        if (cmd.tk_free)
        begin
            tk_valid_next[tk_idx] = 1'b0;
        end

        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.kind  = cmd.emit_kind;
            case (cmd.emit_kind)
                KIND_ONESHOT:
                begin
                    rsp_next.fired_callback = os_cb_rd_reg;
                    rsp_next.status         = ST_OK;
                    rsp_next.last           = 1'b0;
                end
                KIND_TICKER:
                begin
                    rsp_next.fired_callback = tk_cb_rd_reg;
                    rsp_next.status         = ST_OK;
                    rsp_next.last           = 1'b0;
                end
                default:
                begin
                    rsp_next.fired_callback = '0;
                    rsp_next.status         = status_reg;
                    rsp_next.last           = 1'b1;
                end
            endcase
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b0;
            idx_reg        <= '0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            status_reg     <= ST_OK;
            os_valid_reg   <= '0;
            tk_valid_reg   <= '0;
            tk_running_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            dup_reg        <= dup_next;
            free_found_reg <= free_found_next;
            status_reg     <= status_next;
            os_valid_reg   <= os_valid_next;
            tk_valid_reg   <= tk_valid_next;
            tk_running_reg <= tk_running_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg <= free_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        sts.req_type     = req_reg.req_type;
        sts.cb_zero      = (req_reg.callback_id == '0);
        sts.phase_tk     = phase_reg;
        sts.slot_valid   = phase_reg ? tk_valid_reg[tk_idx] : os_valid_reg[os_idx];
        sts.slot_running = tk_running_reg[tk_idx];
        sts.key_match    = (tk_key_rd_reg == req_reg.name_key);
        sts.fire         = phase_reg ? (tk_valid_reg[tk_idx] && tk_running_reg[tk_idx] && tk_due)
                                     : (os_valid_reg[os_idx] && os_due);
        sts.idx_last     = phase_reg ? (idx_reg == IDX_W'(TICKER_SLOTS - 1))
                                     : (idx_reg == IDX_W'(ONESHOT_SLOTS - 1));
        sts.dup          = dup_reg;
        sts.free_found   = free_found_reg;
        sts.out_free     = !rsp_valid_reg || rsp_ready;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef NO_ASSERTIONS
    // A new ticker never lands on a slot that is still in use.
    a_tk_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tk_write |-> !tk_valid_reg[free_reg])
        else $error("ticker written into an occupied slot");

    // Fired entries always carry a usable handle.
    a_fired_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.kind != KIND_STATUS) |-> (rsp_reg.fired_callback != '0))
        else $error("fired result with handle zero");

    // Exactly the status result closes a request.
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_reg.kind == KIND_STATUS) == rsp_reg.last))
        else $error("last flag does not match a status result");
`endif

endmodule

`default_nettype wire

// ----- rtl/tmr_ctrl.sv -----
// Controller state machine that sequences slot scans for every request type.
`default_nettype none

module tmr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tmr_pkg::tmr_sts_t sts,
    output tmr_pkg::tmr_cmd_t cmd
);
    import tmr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_START  = 7'b0000010,
        S_READ   = 7'b0000100,
        S_DIFF   = 7'b0001000,
        S_EVAL   = 7'b0010000,
        S_TADD   = 7'b0100000,
        S_STATUS = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if ((sts.req_type inside {REQ_ADD_ONESHOT, REQ_ADD_TICKER}) && sts.cb_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_BAD_CB;
                    state_next     = S_STATUS;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = (sts.req_type == REQ_TICK) ? S_DIFF : S_EVAL;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (sts.req_type)
                    REQ_ADD_ONESHOT:
                    begin
                        if (!sts.slot_valid)
                        begin
                            cmd.os_write   = 1'b1;
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_OK;
                            state_next     = S_STATUS;
                        end
                        else if (sts.idx_last)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_FULL;
                            state_next     = S_STATUS;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_READ;
                        end
                    end
                    REQ_ADD_TICKER:
                    begin
                        cmd.tk_mark_dup  = sts.slot_valid && sts.key_match;
                        cmd.tk_mark_free = !sts.slot_valid && !sts.free_found;
                        if (sts.idx_last)
                        begin
                            state_next = S_TADD;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_READ;
                        end
                    end
                    REQ_STOP_TICKER:
                    begin
                        if (sts.slot_valid && sts.key_match)
                        begin
                            cmd.tk_stop    = 1'b1;
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_OK;
                            state_next     = S_STATUS;
                        end
                        else if (sts.idx_last)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_NOT_FOUND;
                            state_next     = S_STATUS;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_READ;
                        end
                    end
                    default:
                    begin
                        // Time tick: hold the slot while a fire waits for the result register.
                        if (!sts.fire || sts.out_free)
                        begin
                            cmd.emit      = sts.fire;
                            cmd.emit_kind = sts.phase_tk ? KIND_TICKER : KIND_ONESHOT;
                            cmd.os_clear  = !sts.phase_tk && sts.fire;
                            cmd.tk_reload = sts.phase_tk && sts.fire;
                            cmd.tk_free   = sts.phase_tk && sts.slot_valid && !sts.slot_running;
                            if (!sts.idx_last)
                            begin
                                cmd.idx_inc = 1'b1;
                                state_next  = S_READ;
                            end
                            else if (!sts.phase_tk)
                            begin
                                cmd.idx_clr  = 1'b1;
                                cmd.phase_tk = 1'b1;
                                state_next   = S_READ;
                            end
                            else
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status_val = ST_OK;
                                state_next     = S_STATUS;
                            end
                        end
                    end
                endcase
            end
            S_TADD:
            begin
                cmd.set_status = 1'b1;
                if (sts.dup)
                begin
                    cmd.status_val = ST_DUP_NAME;
                end
                else if (!sts.free_found)
                begin
                    cmd.status_val = ST_FULL;
                end
                else
                begin
                    cmd.tk_write   = 1'b1;
                    cmd.status_val = ST_OK;
                end
                state_next = S_STATUS;
            end
            S_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_STATUS;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

`ifndef NO_ASSERTIONS
    // A result is only loaded when the result register can take it.
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an untaken result");

    // A one-shot is only stored into a free slot.
    a_os_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.os_write |-> !sts.slot_valid)
        else $error("one-shot written into an occupied slot");
`endif

endmodule

`default_nettype wire

// ----- rtl/oneshot_and_periodic_timer_table.sv -----
// Top level of the one-shot and periodic timer table: controller plus datapath.
`default_nettype none

//  Channel  Direction  Handshake              Payload
//  req      in         req_valid / req_ready  tmr_req_t: req_type, callback_id, name_key,
//                                             interval, now
//  rsp      out        rsp_valid / rsp_ready  tmr_rsp_t: kind, fired_callback, status, last
//
//  One request is worked on at a time; req_ready is high only while the controller is idle.
//  Each scanned slot passes through read and evaluate on add and stop requests and through
//  read, subtract and compare on a tick, as the slot store has a single read port and the
//  elapsed-time subtract is registered. A tick scans every one-shot and then every ticker
//  slot, an add ticker every ticker slot, and an add one-shot or a stop until it finds its
//  slot or reaches the last; an add with callback zero is rejected before any scan.
//  A single result register sits on the output, so the scan keeps going while one finished
//  transfer waits; the scan stops on a slot that fires only while that register is still full.
//  Reset clears the valid and running bits of every slot at once; the slot data needs none.

module oneshot_and_periodic_timer_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tmr_pkg::tmr_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tmr_pkg::tmr_rsp_t rsp_data
);
    import tmr_pkg::*;

    tmr_cmd_t cmd;
    tmr_sts_t sts;

    // The controller decides what happens to each slot; the datapath holds the slots,
    // compares elapsed time against each wait or period and drives the result register.
    tmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tmr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire
